[rtl/core/lhsf_pkg.sv]
package lhsf_pkg;

    localparam int COORD_W    = 7;
    localparam int FRAC_W     = 16;
    localparam int HEAT_IN_W  = 16;
    localparam int WGT_W      = 16;
    localparam int COUNT_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MEAN_W     = 16;
    localparam int OFF_W      = COORD_W + FRAC_W;
    localparam int POS_W      = 28;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SAMPLES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DETECT_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INLIER_THR  = 2'd2;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_TEST  = 1'b1;

    localparam logic [COUNT_W-1:0]    RST_NUM_SAMPLES = 7'd64;
    localparam logic [CFG_DATA_W-1:0] RST_DETECT_THR  = 16'd16384;
    localparam logic [CFG_DATA_W-1:0] RST_INLIER_THR  = 16'd58982;
    localparam logic [MEAN_W-1:0]     MEAN_MAX        = 16'hFFFF;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DX_GO,
        S_DX_WAIT,
        S_DY_GO,
        S_DY_WAIT,
        S_POS,
        S_W0,
        S_W1,
        S_W2,
        S_W3,
        S_H0,
        S_H1,
        S_H2,
        S_H3,
        S_ACC,
        S_FIN,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_THR,
        S_INL,
        S_CMP
    } t_state;

    typedef struct packed {
        logic [OFF_W-1:0]   q;
        logic [COUNT_W-1:0] r;
    } t_off;

    function automatic logic [WGT_W-1:0] wgt_ceil(input logic [FRAC_W-1:0] f);
        logic [FRAC_W:0] d;
        d = (FRAC_W + 1)'(1 << FRAC_W) - {1'b0, f};
        return (f != '0) ? d[WGT_W-1:0] : '0;
    endfunction

endpackage

[rtl/core/lhsf_item_if.sv]
interface lhsf_item_if;
    import lhsf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [COORD_W-1:0]   heat_x;
    logic [COORD_W-1:0]   heat_y;
    logic [HEAT_IN_W-1:0] heat_value;
    logic [COORD_W-1:0]   start_x;
    logic [COORD_W-1:0]   start_y;
    logic [COORD_W-1:0]   end_x;
    logic [COORD_W-1:0]   end_y;

    modport source (
        output valid, action, heat_x, heat_y, heat_value, start_x, start_y, end_x, end_y,
        input  ready
    );

    modport sink (
        input  valid, action, heat_x, heat_y, heat_value, start_x, start_y, end_x, end_y,
        output ready
    );

endinterface

[rtl/core/lhsf_result_if.sv]
interface lhsf_result_if;
    import lhsf_pkg::*;

    logic               valid;
    logic               ready;
    logic               line_accepted;
    logic [MEAN_W-1:0]  mean_score;
    logic [COUNT_W-1:0] inlier_tally;

    modport source (
        output valid, line_accepted, mean_score, inlier_tally,
        input  ready
    );

    modport sink (
        input  valid, line_accepted, mean_score, inlier_tally,
        output ready
    );

endinterface

[rtl/core/lhsf_ram.sv]
module lhsf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/lhsf_mul.sv]
module lhsf_mul #(
    parameter int A_W = 32,
    parameter int B_W = 16
) (
    input  logic               i_clk,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic [A_W+B_W-1:0] o_p
);

    logic [A_W+B_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= (A_W + B_W)'(i_a) * (A_W + B_W)'(i_b);
    end

    assign o_p = r_p;

endmodule

[rtl/core/lhsf_div.sv]
module lhsf_div #(
    parameter int DV_W = 23,
    parameter int DS_W = 7
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [DV_W-1:0] i_dividend,
    input  logic [DS_W-1:0] i_divisor,
    output logic            o_done,
    output logic [DV_W-1:0] o_quot,
    output logic [DS_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(DV_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DV_W-1:0]  r_quo;
    logic [DS_W-1:0]  r_rem;
    logic [DS_W-1:0]  r_dvs;

    logic [DS_W:0]    rem_sh;
    logic             ge;
    logic [DS_W-1:0]  n_rem;

    always_comb begin
        rem_sh = {r_rem, r_quo[DV_W-1]};
        ge     = rem_sh >= {1'b0, r_dvs};
        n_rem  = ge ? DS_W'(rem_sh - {1'b0, r_dvs}) : DS_W'(rem_sh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(DV_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_busy <= (r_cnt != CNT_W'(1));
            r_done <= (r_cnt == CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DV_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

[rtl/core/line_heatmap_sample_filter_top.sv]
// Write transaction: taken in S_IDLE, where ready stays high.
// Test transaction: not ready from acceptance until the result is loaded into the output
//   register; the sample count is clamped to 2..MAX_SAMPLES.
// Each sample passes S_POS, S_W0-S_W3, S_H0-S_H3, S_ACC, paced by the single multiplier
//   (eight products per sample) and the single heat RAM port (four corner reads per sample).
// Reset (synchronous): sequencer idle, output empty, registers to 64, 16384, 58982; heat RAM kept.
module line_heatmap_sample_filter_top #(
    parameter int X_SIZE      = 128,
    parameter int Y_SIZE      = 128,
    parameter int MAX_SAMPLES = 64,
    parameter int HEAT_BITS   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    lhsf_item_if.sink                         i_item,
    lhsf_result_if.source                     o_result,
    input  logic                              i_cfg_we,
    input  logic [lhsf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lhsf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import lhsf_pkg::*;

    localparam int X_W     = $clog2(X_SIZE);
    localparam int Y_W     = $clog2(Y_SIZE);
    localparam int DEPTH   = X_SIZE * Y_SIZE;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int MA_W    = 2 * WGT_W;
    localparam int MB_W    = (HEAT_BITS > WGT_W) ? HEAT_BITS : WGT_W;
    localparam int P_W     = MA_W + MB_W;
    localparam int SC_W    = HEAT_BITS + MA_W;
    localparam int SUM_W   = SC_W + $clog2(MAX_SAMPLES + 1);
    localparam int SUMHI_W = SUM_W - MA_W;
    localparam int DV_W    = (SUMHI_W > OFF_W) ? SUMHI_W : OFF_W;
    localparam int THRN_W  = CFG_DATA_W + COUNT_W;
    localparam logic signed [POS_W-1:0] X_TOP = POS_W'((X_SIZE - 1) * (2 ** FRAC_W));
    localparam logic signed [POS_W-1:0] Y_TOP = POS_W'((Y_SIZE - 1) * (2 ** FRAC_W));

    t_state r_state, n_state;

    logic [COUNT_W-1:0]    r_num_samples;
    logic [CFG_DATA_W-1:0] r_detect;
    logic [CFG_DATA_W-1:0] r_inlier;

    logic [COORD_W-1:0] r_sx, r_sy, r_magx, r_magy;
    logic               r_dirx, r_diry;
    logic [COUNT_W-1:0] r_n, r_smp, r_inl;
    t_off               r_step_x, r_step_y, r_off_x, r_off_y;
    logic [X_W-1:0]     r_xf, r_xc;
    logic [Y_W-1:0]     r_yf, r_yc;
    logic [FRAC_W-1:0]  r_fx, r_fy;
    logic [MA_W-1:0]    r_w [4];
    logic [HEAT_BITS-1:0] r_h [4];
    logic [SC_W-1:0]    r_score;
    logic [SUM_W-1:0]   r_sum;
    logic               r_pend;
    logic [THRN_W-1:0]  r_thrn;
    logic [MEAN_W-1:0]  r_mean;

    logic               r_out_valid;
    logic               r_out_acc;
    logic [MEAN_W-1:0]  r_out_mean;
    logic [COUNT_W-1:0] r_out_inl;

    logic [MA_W-1:0]      mul_a;
    logic [MB_W-1:0]      mul_b;
    logic [P_W-1:0]       mul_p;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_addr;
    logic [HEAT_BITS-1:0] ram_rdata;
    logic                 div_start;
    logic [DV_W-1:0]      div_dividend;
    logic [COUNT_W-1:0]   div_divisor;
    logic                 div_done;
    logic [DV_W-1:0]      div_quot;
    logic [COUNT_W-1:0]   div_rem;
    logic                 item_ready;

    logic [COUNT_W-1:0]   nm1;
    logic [POS_W-1:0]     pos_x, pos_y;
    logic [X_W:0]         xc_w;
    logic [Y_W:0]         yc_w;
    logic [X_W-1:0]       xc;
    logic [Y_W-1:0]       yc;
    logic [WGT_W-1:0]     wxc, wyc;
    logic                 wr_in_map;
    logic                 load_out;
    logic [COUNT_W-1:0]   n_sat;

    function automatic t_off advance_off(input t_off cur, input t_off step,
                                         input logic [COUNT_W-1:0] dm1);
        logic [COUNT_W:0] rs;
        logic             carry;
        t_off             nx;
        rs    = {1'b0, cur.r} + {1'b0, step.r};
        carry = rs >= {1'b0, dm1};
        nx.r  = carry ? COUNT_W'(rs - {1'b0, dm1}) : COUNT_W'(rs);
        nx.q  = cur.q + step.q + OFF_W'(carry);
        return nx;
    endfunction

    function automatic logic [POS_W-1:0] axis_pos(input logic [COORD_W-1:0] s, input logic dir,
                                                  input logic [OFF_W-1:0] off,
                                                  input logic signed [POS_W-1:0] top);
        logic signed [POS_W-1:0] base;
        logic signed [POS_W-1:0] delta;
        logic signed [POS_W-1:0] p;
        base  = signed'(POS_W'({s, {FRAC_W{1'b0}}}));
        delta = signed'(POS_W'(off));
        p     = dir ? base + delta : base - delta;
        if (p < 0) begin
            p = '0;
        end else if (p > top) begin
            p = top;
        end
        return p;
    endfunction

    function automatic logic [ADDR_W-1:0] heat_addr(input logic [X_W-1:0] x,
                                                    input logic [Y_W-1:0] y);
        return ADDR_W'(int'(x) * Y_SIZE + int'(y));
    endfunction

    lhsf_ram #(
        .WIDTH (HEAT_BITS),
        .DEPTH (DEPTH)
    ) u_heat_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (HEAT_BITS'(i_item.heat_value)),
        .o_rdata (ram_rdata)
    );

    lhsf_mul #(
        .A_W (MA_W),
        .B_W (MB_W)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    lhsf_div #(
        .DV_W (DV_W),
        .DS_W (COUNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_comb begin
        nm1   = r_n - COUNT_W'(1);
        pos_x = axis_pos(r_sx, r_dirx, r_off_x.q, X_TOP);
        pos_y = axis_pos(r_sy, r_diry, r_off_y.q, Y_TOP);
        xc_w  = {1'b0, pos_x[FRAC_W +: X_W]} + (X_W + 1)'(pos_x[FRAC_W-1:0] != '0);
        yc_w  = {1'b0, pos_y[FRAC_W +: Y_W]} + (Y_W + 1)'(pos_y[FRAC_W-1:0] != '0);
        xc    = (xc_w > (X_W + 1)'(X_SIZE - 1)) ? X_W'(X_SIZE - 1) : xc_w[X_W-1:0];
        yc    = (yc_w > (Y_W + 1)'(Y_SIZE - 1)) ? Y_W'(Y_SIZE - 1) : yc_w[Y_W-1:0];
        wxc   = wgt_ceil(r_fx);
        wyc   = wgt_ceil(r_fy);
        wr_in_map = (int'(i_item.heat_x) < X_SIZE) && (int'(i_item.heat_y) < Y_SIZE);
        load_out  = !r_out_valid || o_result.ready;
        if (r_num_samples < COUNT_W'(2)) begin
            n_sat = COUNT_W'(2);
        end else if (r_num_samples > COUNT_W'(MAX_SAMPLES)) begin
            n_sat = COUNT_W'(MAX_SAMPLES);
        end else begin
            n_sat = r_num_samples;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_item.valid && i_item.action == ACT_TEST) begin
                    n_state = S_DX_GO;
                end
            end
            S_DX_GO:     n_state = S_DX_WAIT;
            S_DX_WAIT: begin
                if (div_done) begin
                    n_state = S_DY_GO;
                end
            end
            S_DY_GO:     n_state = S_DY_WAIT;
            S_DY_WAIT: begin
                if (div_done) begin
                    n_state = S_POS;
                end
            end
            S_POS:       n_state = S_W0;
            S_W0:        n_state = S_W1;
            S_W1:        n_state = S_W2;
            S_W2:        n_state = S_W3;
            S_W3:        n_state = S_H0;
            S_H0:        n_state = S_H1;
            S_H1:        n_state = S_H2;
            S_H2:        n_state = S_H3;
            S_H3:        n_state = S_ACC;
            S_ACC:       n_state = (r_smp == nm1) ? S_FIN : S_POS;
            S_FIN:       n_state = S_MEAN_GO;
            S_MEAN_GO:   n_state = S_MEAN_WAIT;
            S_MEAN_WAIT: begin
                if (div_done) begin
                    n_state = S_THR;
                end
            end
            S_THR:       n_state = S_INL;
            S_INL:       n_state = S_CMP;
            S_CMP: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        item_ready   = 1'b0;
        ram_we       = 1'b0;
        ram_addr     = '0;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = nm1;
        case (r_state)
            S_IDLE: begin
                item_ready = 1'b1;
                ram_we     = i_item.valid && i_item.action == ACT_WRITE && wr_in_map;
                ram_addr   = ADDR_W'(int'(i_item.heat_x) * Y_SIZE + int'(i_item.heat_y));
            end
            S_DX_GO: begin
                div_start    = 1'b1;
                div_dividend = DV_W'({r_magx, {FRAC_W{1'b0}}});
            end
            S_DY_GO: begin
                div_start    = 1'b1;
                div_dividend = DV_W'({r_magy, {FRAC_W{1'b0}}});
            end
            S_W0: begin
                mul_a    = MA_W'(wxc);
                mul_b    = MB_W'(wyc);
                ram_addr = heat_addr(r_xf, r_yf);
            end
            S_W1: begin
                mul_a    = MA_W'(wxc);
                mul_b    = MB_W'(r_fy);
                ram_addr = heat_addr(r_xf, r_yc);
            end
            S_W2: begin
                mul_a    = MA_W'(r_fx);
                mul_b    = MB_W'(wyc);
                ram_addr = heat_addr(r_xc, r_yf);
            end
            S_W3: begin
                mul_a    = MA_W'(r_fx);
                mul_b    = MB_W'(r_fy);
                ram_addr = heat_addr(r_xc, r_yc);
            end
            S_H0: begin
                mul_a = r_w[0];
                mul_b = MB_W'(r_h[0]);
            end
            S_H1: begin
                mul_a = r_w[1];
                mul_b = MB_W'(r_h[1]);
            end
            S_H2: begin
                mul_a = r_w[2];
                mul_b = MB_W'(r_h[2]);
            end
            S_H3: begin
                mul_a = r_w[3];
                mul_b = MB_W'(r_h[3]);
            end
            S_MEAN_GO: begin
                div_start    = 1'b1;
                div_dividend = DV_W'(r_sum[SUM_W-1:MA_W]);
                div_divisor  = r_n;
            end
            S_THR: begin
                mul_a = MA_W'(r_detect);
                mul_b = MB_W'(r_n);
            end
            S_INL, S_CMP: begin
                mul_a = MA_W'(r_inlier);
                mul_b = MB_W'(r_n);
            end
            default: begin
                item_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_num_samples <= RST_NUM_SAMPLES;
            r_detect      <= RST_DETECT_THR;
            r_inlier      <= RST_INLIER_THR;
            r_pend        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= (r_state == S_ACC);
            if (r_state == S_CMP && load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NUM_SAMPLES: r_num_samples <= i_cfg_data[COUNT_W-1:0];
                    CFG_DETECT_THR:  r_detect      <= i_cfg_data;
                    CFG_INLIER_THR:  r_inlier      <= i_cfg_data;
                    default:         r_detect      <= r_detect;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_sum <= r_sum + SUM_W'(r_score);
            if (64'(r_score) > 64'({r_detect, {MA_W{1'b0}}})) begin
                r_inl <= r_inl + COUNT_W'(1);
            end
        end
        case (r_state)
            S_IDLE: begin
                if (i_item.valid && i_item.action == ACT_TEST) begin
                    r_sx    <= i_item.start_x;
                    r_sy    <= i_item.start_y;
                    r_dirx  <= i_item.end_x >= i_item.start_x;
                    r_diry  <= i_item.end_y >= i_item.start_y;
                    r_magx  <= (i_item.end_x >= i_item.start_x) ?
                               i_item.end_x - i_item.start_x : i_item.start_x - i_item.end_x;
                    r_magy  <= (i_item.end_y >= i_item.start_y) ?
                               i_item.end_y - i_item.start_y : i_item.start_y - i_item.end_y;
                    r_n     <= n_sat;
                    r_smp   <= '0;
                    r_off_x <= '0;
                    r_off_y <= '0;
                    r_sum   <= '0;
                    r_inl   <= '0;
                end
            end
            S_DX_WAIT: begin
                if (div_done) begin
                    r_step_x.q <= div_quot[OFF_W-1:0];
                    r_step_x.r <= div_rem;
                end
            end
            S_DY_WAIT: begin
                if (div_done) begin
                    r_step_y.q <= div_quot[OFF_W-1:0];
                    r_step_y.r <= div_rem;
                end
            end
            S_POS: begin
                r_xf    <= pos_x[FRAC_W +: X_W];
                r_fx    <= pos_x[FRAC_W-1:0];
                r_xc    <= xc;
                r_yf    <= pos_y[FRAC_W +: Y_W];
                r_fy    <= pos_y[FRAC_W-1:0];
                r_yc    <= yc;
                r_off_x <= advance_off(r_off_x, r_step_x, nm1);
                r_off_y <= advance_off(r_off_y, r_step_y, nm1);
            end
            S_W1: begin
                r_w[0] <= mul_p[MA_W-1:0];
                r_h[0] <= ram_rdata;
            end
            S_W2: begin
                r_w[1] <= mul_p[MA_W-1:0];
                r_h[1] <= ram_rdata;
            end
            S_W3: begin
                r_w[2] <= mul_p[MA_W-1:0];
                r_h[2] <= ram_rdata;
            end
            S_H0: begin
                r_w[3] <= mul_p[MA_W-1:0];
                r_h[3] <= ram_rdata;
            end
            S_H1: begin
                r_score <= SC_W'(mul_p);
            end
            S_H2, S_H3: begin
                r_score <= r_score + SC_W'(mul_p);
            end
            S_ACC: begin
                r_score <= r_score + SC_W'(mul_p);
                r_smp   <= r_smp + COUNT_W'(1);
            end
            S_MEAN_WAIT: begin
                if (div_done) begin
                    r_mean <= (div_quot > DV_W'(MEAN_MAX)) ? MEAN_MAX : div_quot[MEAN_W-1:0];
                end
            end
            S_INL: begin
                r_thrn <= mul_p[THRN_W-1:0];
            end
            S_CMP: begin
                if (load_out) begin
                    r_out_acc  <= (64'(r_sum) > 64'({r_thrn, {MA_W{1'b0}}})) &&
                                  ({r_inl, {FRAC_W{1'b0}}} > mul_p[THRN_W-1:0]);
                    r_out_mean <= r_mean;
                    r_out_inl  <= r_inl;
                end
            end
            default: begin
                r_smp <= r_smp;
            end
        endcase
    end

    assign i_item.ready           = item_ready;
    assign o_result.valid         = r_out_valid;
    assign o_result.line_accepted = r_out_acc;
    assign o_result.mean_score    = r_out_mean;
    assign o_result.inlier_tally  = r_out_inl;

endmodule
